@@ sv/utf8_budget_truncating_copier_macros.svh @@
// Assertion macros for the UTF-8 budget copier.
// Relies on clk and rst being in scope at the point of use.
`ifndef UTF8_BUDGET_TRUNCATING_COPIER_MACROS_SVH
`define UTF8_BUDGET_TRUNCATING_COPIER_MACROS_SVH

// same-cycle implication, disabled in reset
`define U8BT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define U8BT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/utf8bt_pkg.sv @@
// Shared types, constants and the lead decoder for the UTF-8 budget copier.
// No dependencies.
package utf8bt_pkg;

  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] CODE_CONT = 8'h80;
  localparam logic [7:0] MASK_L2   = 8'hE0;
  localparam logic [7:0] CODE_L2   = 8'hC0;
  localparam logic [7:0] MASK_L3   = 8'hF0;
  localparam logic [7:0] CODE_L3   = 8'hE0;
  localparam logic [7:0] MASK_L4   = 8'hF8;
  localparam logic [7:0] CODE_L4   = 8'hF0;
  localparam int         MAX_RES   = 4;

  // held partial sequence
  typedef struct packed {
    logic [2:0][7:0] pend;
    logic [1:0]      pcnt;
    logic [2:0]      elen;
  } hold_t;

  typedef struct packed {
    logic [15:0] bytes_emitted;
    logic        end_of_fragment;
    logic        out_valid;
    logic [7:0]  out_byte;
  } result_t;

  // sequence length from a lead byte, 0 for a bad lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0)                 len = 3'd1;
    else if ((b & MASK_L2) == CODE_L2) len = 3'd2;
    else if ((b & MASK_L3) == CODE_L3) len = 3'd3;
    else if ((b & MASK_L4) == CODE_L4) len = 3'd4;
    return len;
  endfunction

endpackage

@@ sv/utf8bt_step.sv @@
// Decision logic for one byte: builds up to four results and the next state.
// Depends on utf8bt_pkg.
module utf8bt_step #(
  parameter int BUDGET_BITS = 16
) (
  input  logic [7:0]                         in_byte,
  input  logic                               first,
  input  logic                               last,
  input  logic [15:0]                        byte_budget,
  input  utf8bt_pkg::hold_t                  hold,
  input  logic [BUDGET_BITS-1:0]             budget_left,
  input  logic [BUDGET_BITS-1:0]             emitted_count,
  input  logic                               stopped,
  output utf8bt_pkg::result_t [3:0]          res,
  output logic [2:0]                         res_count,
  output utf8bt_pkg::hold_t                  hold_next,
  output logic [BUDGET_BITS-1:0]             budget_left_next,
  output logic [BUDGET_BITS-1:0]             emitted_count_next,
  output logic                               stopped_next
);

  localparam int EW = (BUDGET_BITS > 16) ? BUDGET_BITS : 16;

  logic [EW-1:0]          bud_ext;
  logic [EW-1:0]          max_ext;
  logic [BUDGET_BITS-1:0] bud_sat;
  logic [BUDGET_BITS-1:0] bl;
  logic [BUDGET_BITS-1:0] em;
  logic                   st;
  utf8bt_pkg::hold_t      h;
  logic [2:0]             lead_len;
  logic [2:0]             bl_small;
  logic [2:0]             nq;
  logic [2:0]             n_cand;
  logic [2:0]             k;
  logic [2:0]             end_idx;
  logic                   avail;
  logic                   cont;
  logic                   seq_done;
  logic                   over;
  logic                   use_lead;
  logic                   lead_item;
  logic [7:0]             lead_byte;
  logic [3:0][7:0]        cand;

  always_comb begin
    bud_ext = EW'(byte_budget);
    max_ext = EW'({BUDGET_BITS{1'b1}});
    bud_sat = (bud_ext > max_ext) ? {BUDGET_BITS{1'b1}} : bud_ext[BUDGET_BITS-1:0];

    h  = hold;
    bl = budget_left;
    em = emitted_count;
    st = stopped;
    if (first) begin
      h.pcnt = 2'd0;
      h.elen = 3'd0;
      bl     = bud_sat;
      em     = '0;
      st     = (bud_sat == '0);
    end

    avail    = !st && (bl != '0);
    bl_small = (bl >= BUDGET_BITS'(4)) ? 3'd4 : bl[2:0];
    cont     = ((in_byte & utf8bt_pkg::MASK_CONT) == utf8bt_pkg::CODE_CONT);
    lead_len = utf8bt_pkg::seq_len(in_byte);

    seq_done  = 1'b0;
    over      = 1'b0;
    use_lead  = 1'b0;
    lead_item = 1'b0;
    lead_byte = utf8bt_pkg::QMARK;
    nq        = 3'd0;
    hold_next      = h;
    hold_next.pcnt = 2'd0;
    hold_next.elen = 3'd0;

    if (h.pcnt == 2'd0) begin
      use_lead = 1'b1;
    end else if (cont) begin
      if ({1'b0, h.pcnt} + 3'd1 == h.elen) begin
        seq_done = 1'b1;
      end else if (h.pcnt != 2'd3) begin
        hold_next.pend[h.pcnt] = in_byte;
        if (last) begin
          nq = {1'b0, h.pcnt} + 3'd1;
        end else begin
          hold_next.pcnt = h.pcnt + 2'd1;
          hold_next.elen = h.elen;
        end
      end
    end else begin
      // broken tail: held bytes each turn into a replacement
      nq       = {1'b0, h.pcnt};
      use_lead = 1'b1;
    end

    if (use_lead) begin
      priority if (lead_len == 3'd0) begin
        lead_item = 1'b1;
      end else if (lead_len == 3'd1) begin
        lead_item = 1'b1;
        lead_byte = in_byte;
      end else if (last) begin
        lead_item = 1'b1;
      end else if (avail && (bl_small > nq)) begin
        hold_next.pend[0] = in_byte;
        hold_next.pcnt    = 2'd1;
        hold_next.elen    = lead_len;
      end
    end

    n_cand = nq + {2'b00, lead_item};

    for (int j = 0; j < 3; j++) begin
      if (seq_done) begin
        cand[j] = (j < int'(h.pcnt)) ? h.pend[j] : in_byte;
      end else begin
        cand[j] = (j < int'(nq)) ? utf8bt_pkg::QMARK : lead_byte;
      end
    end
    cand[3] = seq_done ? in_byte : ((nq == 3'd4) ? utf8bt_pkg::QMARK : lead_byte);

    if (seq_done) begin
      over = !avail || (h.elen > bl_small);
      k    = over ? 3'd0 : h.elen;
    end else begin
      k = !avail ? 3'd0 : ((n_cand < bl_small) ? n_cand : bl_small);
    end

    budget_left_next   = bl - BUDGET_BITS'(k);
    emitted_count_next = em + BUDGET_BITS'(k);
    stopped_next       = st || over || last || (budget_left_next == '0);

    res_count = (last && (k == 3'd0)) ? 3'd1 : k;
    end_idx   = (k == 3'd0) ? 3'd0 : k - 3'd1;

    for (int j = 0; j < utf8bt_pkg::MAX_RES; j++) begin
      res[j] = '0;
      if (j < int'(k)) begin
        res[j].out_byte  = cand[j];
        res[j].out_valid = 1'b1;
      end
      if (last && (j == int'(end_idx))) begin
        res[j].end_of_fragment = 1'b1;
        res[j].bytes_emitted   = 16'(emitted_count_next);
      end
    end
  end

endmodule

@@ sv/utf8_budget_truncating_copier.sv @@
// Top level of the UTF-8 budget-limited truncating copier.
// Depends on utf8bt_pkg, utf8bt_step and the assertion macro header.
//
// Usage: bytes of a fragment arrive on s_axis, one request per byte; tuser
// marks the first byte (its tdata carries the byte budget) and tlast the final
// one. Results leave on m_axis: tdata holds the byte and, on the final result
// of a fragment (tlast), the count of bytes emitted; tuser says the byte is
// real. A fragment that emits nothing still ends with one result, tuser low.
// A byte is registered in the input register on acceptance; its results are
// then loaded into the result list register, which drives m_axis. One byte
// per cycle while the result list keeps up. A byte yields zero to four
// results and the single result port drains them at one per cycle while
// m_axis_tready is high, so a byte that closes a multi-byte sequence or
// flushes held bytes waits on earlier results; held-only bytes never wait.
// Reset empties the input and result registers and clears all counters; no
// byte outside a fragment is copied until a first byte arrives.
// When the receiver stalls, results hold on m_axis. Bytes that only extend a
// held sequence still pass; s_axis_tready drops once a byte with results
// waits in the input register behind results not yet taken.
`include "utf8_budget_truncating_copier_macros.svh"

module utf8_budget_truncating_copier #(
  parameter int BUDGET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // in_byte[7:0], byte_budget[23:8]
  input  logic        s_axis_tuser,  // first_of_fragment
  input  logic        s_axis_tlast,  // last_of_fragment
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_byte[7:0], bytes_emitted[23:8]
  output logic        m_axis_tuser,  // out_valid
  output logic        m_axis_tlast   // end_of_fragment
);

  logic                          in_v;
  logic [7:0]                    in_byte;
  logic                          in_first;
  logic                          in_last;
  logic [15:0]                   in_budget;

  utf8bt_pkg::hold_t             hold;
  utf8bt_pkg::hold_t             hold_next;
  logic [BUDGET_BITS-1:0]        budget_left;
  logic [BUDGET_BITS-1:0]        budget_left_next;
  logic [BUDGET_BITS-1:0]        emitted_count;
  logic [BUDGET_BITS-1:0]        emitted_count_next;
  logic                          stopped;
  logic                          stopped_next;

  utf8bt_pkg::result_t [3:0]     res;
  logic [2:0]                    res_count;
  utf8bt_pkg::result_t [3:0]     lst;
  logic [2:0]                    rem;
  logic [1:0]                    ptr;
  utf8bt_pkg::result_t           cur;

  logic                          list_free;
  logic                          move;
  logic                          load;
  logic                          in_take;
  logic                          out_take;

  utf8bt_step #(
    .BUDGET_BITS (BUDGET_BITS)
  ) u_step (
    .in_byte            (in_byte),
    .first              (in_first),
    .last               (in_last),
    .byte_budget        (in_budget),
    .hold               (hold),
    .budget_left        (budget_left),
    .emitted_count      (emitted_count),
    .stopped            (stopped),
    .res                (res),
    .res_count          (res_count),
    .hold_next          (hold_next),
    .budget_left_next   (budget_left_next),
    .emitted_count_next (emitted_count_next),
    .stopped_next       (stopped_next)
  );

  assign cur           = lst[ptr];
  assign m_axis_tvalid = (rem != 3'd0);
  assign m_axis_tdata  = {cur.bytes_emitted, cur.out_byte};
  assign m_axis_tuser  = cur.out_valid;
  assign m_axis_tlast  = cur.end_of_fragment;

  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign list_free     = (rem == 3'd0) || ((rem == 3'd1) && m_axis_tready);
  assign move          = in_v && ((res_count == 3'd0) || list_free);
  assign load          = move && (res_count != 3'd0);
  assign s_axis_tready = !in_v || move;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v          <= 1'b0;
      rem           <= 3'd0;
      ptr           <= 2'd0;
      hold.pcnt     <= 2'd0;
      hold.elen     <= 3'd0;
      budget_left   <= '0;
      emitted_count <= '0;
      stopped       <= 1'b0;
    end else begin
      if (in_take) begin
        in_v <= 1'b1;
      end else if (move) begin
        in_v <= 1'b0;
      end
      if (load) begin
        rem <= res_count;
        ptr <= 2'd0;
      end else if (out_take) begin
        rem <= rem - 3'd1;
        ptr <= ptr + 2'd1;
      end
      if (move) begin
        hold          <= hold_next;
        budget_left   <= budget_left_next;
        emitted_count <= emitted_count_next;
        stopped       <= stopped_next;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte   <= s_axis_tdata[7:0];
      in_budget <= s_axis_tdata[23:8];
      in_first  <= s_axis_tuser;
      in_last   <= s_axis_tlast;
    end
    if (load) begin
      lst <= res;
    end
  end

  `U8BT_ASSERT_IMP(a_hold_not_stopped, hold.pcnt != 2'd0, !stopped, "sequence held while stopped")
  `U8BT_ASSERT_IMP(a_hold_len, hold.pcnt != 2'd0, hold.elen > {1'b0, hold.pcnt}, "bad held count")
  `U8BT_ASSERT_IMP(a_empty_is_end, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "empty result not at fragment end")
  `U8BT_ASSERT_IMP(a_load_free, load && (rem != 3'd0), (rem == 3'd1) && m_axis_tready, "result list overwritten")

endmodule
